// ===== src/quaternion_product_normalize_assert.svh =====
// Assertion macros shared by the quaternion product normalizer.
`ifndef QUATERNION_PRODUCT_NORMALIZE_ASSERT_SVH
`define QUATERNION_PRODUCT_NORMALIZE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define QPN_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("quaternion_product_normalize: assertion failed");

// Implication across a fixed number of cycles.
`define QPN_ASSERT_DLY(lbl, ante, dly, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##dly (cons)) \
    else $error("quaternion_product_normalize: assertion failed");

`endif

// ===== src/qpn_pkg.sv =====
// Types and constants of the quaternion product normalizer.
`default_nettype none
package qpn_pkg;

  localparam int unsigned UnitStages = 32;

  // Hamilton product terms: part i takes a[j] times b[TermB[i][j]],
  // negated where bit j of TermN[i] is set. Index 0..3 is x, y, z, w.
  localparam logic [1:0] TermB [4][4] = '{
    '{2'd3, 2'd2, 2'd1, 2'd0},
    '{2'd2, 2'd3, 2'd0, 2'd1},
    '{2'd1, 2'd0, 2'd3, 2'd2},
    '{2'd0, 2'd1, 2'd2, 2'd3}
  };
  localparam logic [3:0] TermN [4] = '{4'b0100, 4'b0001, 4'b0010, 4'b0111};

  typedef struct packed {
    logic       op;
    logic [3:0] neg;
    logic       deg;
  } side_t;

endpackage
`default_nettype wire

// ===== src/qpn_rsqrt.sv =====
// Pipelined digit recurrence: largest y with y*y*n2 <= sq*2^62, per lane.
`default_nettype none
module qpn_rsqrt (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  qpn_pkg::side_t      side_i,
  input  logic [61:0]         n2_i,
  input  logic [3:0][59:0]    sq_i,
  output logic                valid_o,
  output qpn_pkg::side_t      side_o,
  output logic [3:0][31:0]    y_o
);
  import qpn_pkg::*;

  logic [UnitStages:1]                 vld_q;
  side_t                               side_q [1:UnitStages];
  logic [61:0]                         n2_q   [1:UnitStages];
  logic [3:0][127:0]                   d_q    [1:UnitStages];
  logic [3:0][95:0]                    p_q    [1:UnitStages];
  logic [3:0][31:0]                    y_q    [1:UnitStages];

  for (genvar s = 0; s < UnitStages; s++) begin : g_stage
    localparam int unsigned K = UnitStages - 1 - s;
    logic              vld_in;
    side_t             side_in;
    logic [61:0]       n2_in;
    logic [3:0][127:0] d_in;
    logic [3:0][95:0]  p_in;
    logic [3:0][31:0]  y_in;
    logic [3:0][127:0] t;
    logic [3:0]        take;

    // The first stage starts from the input; the remainder starts at sq*2^62.
    if (s == 0) begin : g_first
      always_comb begin
        vld_in  = valid_i;
        side_in = side_i;
        n2_in   = n2_i;
        for (int i = 0; i < 4; i++) begin
          d_in[i] = {6'b0, sq_i[i], 62'b0};
          p_in[i] = '0;
          y_in[i] = '0;
        end
      end
    end else begin : g_next
      always_comb begin
        vld_in  = vld_q[s];
        side_in = side_q[s];
        n2_in   = n2_q[s];
        d_in    = d_q[s];
        p_in    = p_q[s];
        y_in    = y_q[s];
      end
    end

    // Setting bit K of y adds n2*2^K*(2y + 2^K) to y*y*n2.
    always_comb begin
      for (int i = 0; i < 4; i++) begin
        t[i]    = (128'(p_in[i]) << (K + 1)) + (128'(n2_in) << (2 * K));
        take[i] = d_in[i] >= t[i];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else begin
        vld_q[s+1] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      side_q[s+1] <= side_in;
      n2_q[s+1]   <= n2_in;
      for (int i = 0; i < 4; i++) begin
        if (take[i]) begin
          d_q[s+1][i] <= d_in[i] - t[i];
          p_q[s+1][i] <= p_in[i] + (96'(n2_in) << K);
          y_q[s+1][i] <= y_in[i] | (32'd1 << K);
        end else begin
          d_q[s+1][i] <= d_in[i];
          p_q[s+1][i] <= p_in[i];
          y_q[s+1][i] <= y_in[i];
        end
      end
    end
  end

  assign valid_o = vld_q[UnitStages];
  assign side_o  = side_q[UnitStages];
  assign y_o     = y_q[UnitStages];

endmodule
`default_nettype wire

// ===== src/quaternion_product_normalize.sv =====
// Top level: normalized quaternion product and rotation vector pipeline.
`default_nettype none
// Takes one quaternion pair per cycle (busy_o stays low) and gives each
// result on done_o for one cycle; the receiver cannot stall and nothing is
// buffered. Each result passes through the 32 stages of the bit-per-stage
// square root and division recurrence, one stage per bit of the unrounded
// unit magnitude, plus ten stages of multiply, sum, scaling and output
// logic. Results appear in start order.
module quaternion_product_normalize (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               op_i,
  input  logic signed [31:0] a_x_i,
  input  logic signed [31:0] a_y_i,
  input  logic signed [31:0] a_z_i,
  input  logic signed [31:0] a_w_i,
  input  logic signed [31:0] b_x_i,
  input  logic signed [31:0] b_y_i,
  input  logic signed [31:0] b_z_i,
  input  logic signed [31:0] b_w_i,
  output logic               done_o,
  output logic signed [31:0] r_x_o,
  output logic signed [31:0] r_y_o,
  output logic signed [31:0] r_z_o,
  output logic signed [31:0] r_w_o,
  output logic               degenerate_o
);
  import qpn_pkg::*;

  localparam int unsigned Latency = 10 + UnitStages;

  logic [8:0] vld_q;

  // Stage A: sign and magnitude of every input part; op flips the signs of b's vector parts.
  logic [3:0][31:0] in_a, in_b, ma_d, mb_d, ma_q, mb_q;
  logic [3:0]       sa_d, sb_d, sa_q, sb_q;
  logic             op_a_q;

  assign in_a = {a_w_i, a_z_i, a_y_i, a_x_i};
  assign in_b = {b_w_i, b_z_i, b_y_i, b_x_i};

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ma_d[i] = in_a[i][31] ? (~in_a[i] + 32'd1) : in_a[i];
      mb_d[i] = in_b[i][31] ? (~in_b[i] + 32'd1) : in_b[i];
      sa_d[i] = in_a[i][31];
      sb_d[i] = in_b[i][31] ^ (op_i && (i < 3));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[7:0], start_i && !busy_o};
    end
  end

  always_ff @(posedge clk_i) begin
    ma_q   <= ma_d;
    mb_q   <= mb_d;
    sa_q   <= sa_d;
    sb_q   <= sb_d;
    op_a_q <= op_i;
  end

  // Stage B: the sixteen partial products and their signs.
  logic [3:0][3:0][63:0] prod_q;
  logic [3:0][3:0]       ps_q;
  logic                  op_b_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        prod_q[i][j] <= 64'(ma_q[j]) * 64'(mb_q[TermB[i][j]]);
        ps_q[i][j]   <= sa_q[j] ^ sb_q[TermB[i][j]] ^ TermN[i][j];
      end
    end
    op_b_q <= op_a_q;
  end

  // Stage C: exact signed sum of four terms per part.
  logic [3:0][65:0] sum_d, sum_q;
  logic             op_c_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sum_d[i] = '0;
      for (int j = 0; j < 4; j++) begin
        if (ps_q[i][j]) begin
          sum_d[i] = sum_d[i] - {2'b0, prod_q[i][j]};
        end else begin
          sum_d[i] = sum_d[i] + {2'b0, prod_q[i][j]};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q  <= sum_d;
    op_c_q <= op_b_q;
  end

  // Stage D: magnitudes; the sign flip for a negative scalar part is folded
  // into the per-part negate flags here.
  logic [3:0][64:0] mag_d, mag_q;
  side_t            side_d, side_d_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag_d[i]      = sum_q[i][65] ? 65'(-sum_q[i]) : sum_q[i][64:0];
      side_d.neg[i] = sum_q[i][65] ^ sum_q[3][65];
    end
    side_d.op  = op_c_q;
    side_d.deg = (mag_d[0] | mag_d[1] | mag_d[2] | mag_d[3]) == '0;
  end

  always_ff @(posedge clk_i) begin
    mag_q    <= mag_d;
    side_d_q <= side_d;
  end

  // Stage E1: leading-one search within each byte of the combined magnitude.
  logic [71:0]      orv;
  logic [8:0]       gnz_d, gnz_q;
  logic [8:0][3:0]  glen_d, glen_q;
  logic [3:0][64:0] mag_e_q;
  side_t            side_e_q;

  always_comb begin
    orv = {7'b0, mag_q[0] | mag_q[1] | mag_q[2] | mag_q[3]};
    for (int g = 0; g < 9; g++) begin
      gnz_d[g]  = |orv[8*g +: 8];
      glen_d[g] = '0;
      for (int b = 0; b < 8; b++) begin
        if (orv[8*g + b]) begin
          glen_d[g] = 4'(b + 1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    gnz_q    <= gnz_d;
    glen_q   <= glen_d;
    mag_e_q  <= mag_q;
    side_e_q <= side_d_q;
  end

  // Stage E2: bit length of the largest part.
  logic [6:0]       len_d, len_q;
  logic [3:0][64:0] mag_f_q;
  side_t            side_f_q;

  always_comb begin
    len_d = '0;
    for (int g = 0; g < 9; g++) begin
      if (gnz_q[g]) begin
        len_d = 7'(8 * g) + 7'(glen_q[g]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    len_q    <= len_d;
    mag_f_q  <= mag_e_q;
    side_f_q <= side_e_q;
  end

  // Stage F: scale so the largest part has bit length 30, truncating.
  logic [3:0][94:0] wide;
  logic [3:0][29:0] v_q;
  side_t            side_g_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      wide[i] = {mag_f_q[i], 30'b0} >> len_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      v_q[i] <= wide[i][29:0];
    end
    side_g_q <= side_f_q;
  end

  // Stage G: squares of the scaled parts.
  logic [3:0][59:0] sq_q;
  side_t            side_h_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      sq_q[i] <= 60'(v_q[i]) * 60'(v_q[i]);
    end
    side_h_q <= side_g_q;
  end

  // Stage H: squared norm.
  logic [61:0]      n2_q;
  logic [3:0][59:0] sq_n_q;
  side_t            side_n_q;

  always_ff @(posedge clk_i) begin
    n2_q     <= 62'(sq_q[0]) + 62'(sq_q[1]) + 62'(sq_q[2]) + 62'(sq_q[3]);
    sq_n_q   <= sq_q;
    side_n_q <= side_h_q;
  end

  logic             u_valid;
  side_t            u_side;
  logic [3:0][31:0] u_y;

  qpn_rsqrt u_rsqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_q[8]),
    .side_i  (side_n_q),
    .n2_i    (n2_q),
    .sq_i    (sq_n_q),
    .valid_o (u_valid),
    .side_o  (u_side),
    .y_o     (u_y)
  );

  // Output stage: y is twice the magnitude, so halving with carry rounds
  // to nearest with ties away from zero.
  logic [3:0][32:0] y1;
  logic [3:0][31:0] r_mag, r_d, r_q;
  logic             done_q, deg_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      y1[i]    = 33'(u_y[i]) + 33'd1;
      r_mag[i] = u_side.op ? y1[i][32:1] << 1 : 32'(y1[i][32:1]);
      if (u_side.op && !u_side.neg[i] && r_mag[i][31]) begin
        r_mag[i] = 32'h7FFF_FFFF;
      end
      r_d[i] = u_side.neg[i] ? (~r_mag[i] + 32'd1) : r_mag[i];
      if (u_side.deg || (u_side.op && (i == 3))) begin
        r_d[i] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= u_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q   <= r_d;
    deg_q <= u_side.deg;
  end

  assign busy_o       = 1'b0;
  assign done_o       = done_q;
  assign r_x_o        = r_q[0];
  assign r_y_o        = r_q[1];
  assign r_z_o        = r_q[2];
  assign r_w_o        = r_q[3];
  assign degenerate_o = deg_q;

`include "quaternion_product_normalize_assert.svh"

  `QPN_ASSERT_DLY(a_latency, start_i && !busy_o, Latency, done_o)
  `QPN_ASSERT_IMP(a_deg_zero, done_o && degenerate_o,
                  r_x_o == 0 && r_y_o == 0 && r_z_o == 0 && r_w_o == 0)
  `QPN_ASSERT_IMP(a_w_nonneg, done_o, !r_w_o[31])

endmodule
`default_nettype wire
